@@ hw/rtl/msr_pkg.sv @@
// Shared constants and types for the multicast stub router.
package msr_pkg;

    localparam int PORTS      = 4;   // link slots on each side
    localparam int TAG_W      = 16;  // tag field width on the links
    localparam int MASK_W     = 4;   // request mask field width
    localparam int IN_SLOT_W  = 1 + TAG_W + MASK_W;
    localparam int OUT_SLOT_W = 1 + TAG_W;
    localparam int IN_W       = 88;  // PORTS * IN_SLOT_W rounded up to bytes
    localparam int OUT_W      = 72;  // PORTS * OUT_SLOT_W + 1 rounded up to bytes
    localparam int OVF_BIT    = PORTS * OUT_SLOT_W;
    localparam int IDX_W      = 2;   // input index width

    // Per-lane status seen by the arbiter.
    typedef struct packed {
        logic front_valid;
        logic drop;
    } t_lane_stat;

endpackage

@@ hw/rtl/msr_lane.sv @@
// One input lane: request FIFO memory, front entry tracking and pop logic.
module msr_lane #(
    parameter int FIFO_DEPTH = 128,
    parameter int TW         = 16,
    parameter int MW         = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_valid,
    input  logic [TW-1:0]        i_tag,
    input  logic [MW-1:0]        i_mask,
    input  logic [MW-1:0]        i_grant,
    output msr_pkg::t_lane_stat  o_stat,
    output logic [TW-1:0]        o_front_tag,
    output logic [MW-1:0]        o_front_mask
);
    import msr_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = TW + MW;

    logic [EW-1:0] r_mem [FIFO_DEPTH];
    logic [EW-1:0] r_q;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic          r_fresh;
    logic [TW-1:0] r_ftag;
    logic [MW-1:0] r_fmask;

    logic          w_empty;
    logic          w_full;
    logic          w_push_ok;
    logic          w_push;
    logic          w_pop;
    logic          w_fwd;
    logic [SW-1:0] w_sum;
    logic [AW-1:0] w_tail;
    logic [AW-1:0] w_head_inc;
    logic [AW-1:0] n_head;
    logic [CW-1:0] n_count;
    logic [AW-1:0] w_rd_addr;
    logic [TW-1:0] w_ftag;
    logic [MW-1:0] w_fmask;
    logic [MW-1:0] w_resid;

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == CW'(FIFO_DEPTH));
    assign w_push_ok = i_valid & ~w_full;
    assign w_push    = i_step & w_push_ok;

    // tail = head + count, wrapped once
    assign w_sum  = SW'(r_head) + SW'(r_count);
    assign w_tail = (w_sum >= SW'(FIFO_DEPTH)) ? AW'(w_sum - SW'(FIFO_DEPTH)) : AW'(w_sum);
    assign w_head_inc = (r_head == AW'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // an empty lane serves the word arriving now
    always_comb begin
        if (w_empty) begin
            w_ftag  = i_tag;
            w_fmask = i_mask;
        end else if (r_fresh) begin
            w_ftag  = r_q[EW-1:MW];
            w_fmask = r_q[MW-1:0];
        end else begin
            w_ftag  = r_ftag;
            w_fmask = r_fmask;
        end
    end

    assign w_resid = w_fmask & ~i_grant;
    assign w_pop   = i_step & (~w_empty | w_push_ok) & (w_resid == '0);
    assign n_head  = w_pop ? w_head_inc : r_head;
    assign n_count = r_count + CW'(w_push) - CW'(w_pop);
    // next front is being written this edge: bypass the memory
    assign w_fwd   = w_pop & w_push & (w_tail == w_head_inc);
    assign w_rd_addr = i_step ? n_head : r_head;

    assign o_stat.front_valid = ~w_empty | w_push_ok;
    assign o_stat.drop        = i_valid & w_full;
    assign o_front_tag        = w_ftag;
    assign o_front_mask       = w_fmask;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[w_tail] <= {i_tag, i_mask};
        end
        r_q <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_fresh <= 1'b0;
        end else if (i_step) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_fresh <= w_pop & ~w_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (w_fwd) begin
                r_ftag  <= i_tag;
                r_fmask <= i_mask;
            end else begin
                r_ftag  <= w_ftag;
                r_fmask <= w_resid;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FIFO_DEPTH))
        else $error("lane fill level beyond depth");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_count) && $stable(r_head))
        else $error("lane state moved without a step");

    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("lane push lost");

endmodule

@@ hw/rtl/multicast_stub_router.sv @@
// Multicast stub router top level: input lanes, output arbitration, output register.
//
// Each accepted input word carries one frame slot per input link; the router
// queues valid frames in a per-input FIFO, serves every output from the front
// entry of the highest-numbered input that requests it, and returns one output
// word per input word, in order. A new word is taken every cycle
// whenever the output register is empty or being drained; the FIFO
// memories are read ahead with a registered port, and the pushed word
// is bypassed to the front when its FIFO is empty or about to expose it. A
// frame that meets a full FIFO is dropped and flags overflow in the same
// output word. Mask bits for absent outputs are discarded on entry.
module multicast_stub_router #(
    parameter int NUM_INPUTS  = 4,
    parameter int NUM_OUTPUTS = 4,
    parameter int FIFO_DEPTH  = 128,
    parameter int TAG_BITS    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // per input k from 0 up: ink_valid, ink_tag[15:0], ink_mask[3:0]; zero pad to 88
    input  logic [msr_pkg::IN_W-1:0] i_s_tdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // per output k from 0 up: outk_valid, outk_tag[15:0]; then overflow; zero pad to 72
    output logic [msr_pkg::OUT_W-1:0] o_m_tdata
);
    import msr_pkg::*;

    localparam int SW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    logic                    r_m_tvalid;
    logic [OUT_W-1:0]        r_m_tdata;
    logic [OUT_W-1:0]        n_m_tdata;
    logic                    w_step;
    t_lane_stat              w_stat  [PORTS];
    logic [SW-1:0]           w_ftag  [PORTS];
    logic [NUM_OUTPUTS-1:0]  w_fmask [PORTS];
    logic [NUM_OUTPUTS-1:0]  w_grant [PORTS];

    assign o_s_tready = ~r_m_tvalid | i_m_tready;
    assign w_step     = i_s_tvalid & o_s_tready;

    for (genvar gi = 0; gi < PORTS; gi++) begin : g_lane
        if (gi < NUM_INPUTS) begin : g_on
            msr_lane #(
                .FIFO_DEPTH (FIFO_DEPTH),
                .TW         (SW),
                .MW         (NUM_OUTPUTS)
            ) u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_step       (w_step),
                .i_valid      (i_s_tdata[gi*IN_SLOT_W]),
                .i_tag        (i_s_tdata[gi*IN_SLOT_W+1 +: SW]),
                .i_mask       (i_s_tdata[gi*IN_SLOT_W+1+TAG_W +: NUM_OUTPUTS]),
                .i_grant      (w_grant[gi]),
                .o_stat       (w_stat[gi]),
                .o_front_tag  (w_ftag[gi]),
                .o_front_mask (w_fmask[gi])
            );
        end else begin : g_off
            assign w_stat[gi]  = '0;
            assign w_ftag[gi]  = '0;
            assign w_fmask[gi] = '0;
        end
    end

    // per output: last hit in ascending order is the highest-priority input
    always_comb begin
        logic             hit;
        logic [IDX_W-1:0] sel;
        logic             ovf;
        n_m_tdata = '0;
        ovf       = 1'b0;
        for (int i = 0; i < PORTS; i++) begin
            w_grant[i] = '0;
            ovf        = ovf | w_stat[i].drop;
        end
        for (int o = 0; o < NUM_OUTPUTS; o++) begin
            hit = 1'b0;
            sel = '0;
            for (int i = 0; i < NUM_INPUTS; i++) begin
                if (w_stat[i].front_valid && w_fmask[i][o]) begin
                    hit = 1'b1;
                    sel = IDX_W'(i);
                end
            end
            if (hit) begin
                w_grant[sel][o] = 1'b1;
                n_m_tdata[o*OUT_SLOT_W] = 1'b1;
                n_m_tdata[o*OUT_SLOT_W+1 +: TAG_W] = TAG_W'(w_ftag[sel]);
            end
        end
        n_m_tdata[OVF_BIT] = ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_step) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_m_tdata <= n_m_tdata;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_m_tvalid)
        else $error("accepted word produced no output word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed while stalled");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with an empty output register");

endmodule

@@ tb/sv/msr_route_checker.sv @@
// Checker for the multicast stub router: predicts every output word and compares it.
`timescale 1ns / 100ps
module msr_route_checker #(
    parameter int NUM_INPUTS  = 4,
    parameter int NUM_OUTPUTS = 4,
    parameter int FIFO_DEPTH  = 128,
    parameter int TAG_BITS    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    // per input k from 0 up: ink_valid, ink_tag[15:0], ink_mask[3:0]; zero pad to 88
    input  logic [msr_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    // per output k from 0 up: outk_valid, outk_tag[15:0]; then overflow; zero pad to 72
    input  logic [msr_pkg::OUT_W-1:0] i_m_tdata,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_drop_words
);
    import msr_pkg::*;

    localparam logic [31:0] TAG_KEEP = 32'hFFFF_FFFF >> (32 - TAG_BITS);
    localparam logic [MASK_W-1:0] OUT_KEEP = MASK_W'((1 << NUM_OUTPUTS) - 1);

    // per-input request queues of the predictor
    logic [TAG_W-1:0]  req_tag  [PORTS][FIFO_DEPTH];
    logic [MASK_W-1:0] req_mask [PORTS][FIFO_DEPTH];
    int                req_head [PORTS];
    int                req_fill [PORTS];

    logic [OUT_W-1:0]  routed_q [$];
    int                err_cnt;
    int                word_cnt;
    int                drop_cnt;

    // One router tick: push, serve from the highest input, pop drained fronts.
    task automatic route_word(input logic [IN_W-1:0] w, output logic [OUT_W-1:0] r);
        logic [TAG_W-1:0]  tg;
        logic [MASK_W-1:0] mk;
        logic              dropped;
        logic              hit;
        int                base;
        int                slot;
        r       = '0;
        dropped = 1'b0;
        for (int i = 0; i < NUM_INPUTS; i++) begin
            base = i * IN_SLOT_W;
            if (w[base]) begin
                tg = w[base + 1 +: TAG_W] & TAG_KEEP[TAG_W-1:0];
                mk = w[base + 1 + TAG_W +: MASK_W] & OUT_KEEP;
                if (req_fill[i] >= FIFO_DEPTH) begin
                    dropped = 1'b1;
                end else begin
                    slot = (req_head[i] + req_fill[i]) % FIFO_DEPTH;
                    req_tag[i][slot]  = tg;
                    req_mask[i][slot] = mk;
                    req_fill[i]++;
                end
            end
        end
        for (int o = 0; o < NUM_OUTPUTS; o++) begin
            hit = 1'b0;
            for (int i = NUM_INPUTS - 1; i >= 0; i--) begin
                if (!hit && req_fill[i] != 0 && req_mask[i][req_head[i]][o]) begin
                    hit = 1'b1;
                    r[o * OUT_SLOT_W] = 1'b1;
                    r[o * OUT_SLOT_W + 1 +: TAG_W] = req_tag[i][req_head[i]];
                    req_mask[i][req_head[i]][o] = 1'b0;
                end
            end
        end
        for (int i = 0; i < NUM_INPUTS; i++) begin
            if (req_fill[i] != 0 && req_mask[i][req_head[i]] == '0) begin
                req_head[i] = (req_head[i] + 1) % FIFO_DEPTH;
                req_fill[i]--;
            end
        end
        r[OVF_BIT] = dropped;
    endtask

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t: output word %0d: %s", $realtime, word_cnt, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            note_error($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    always @(posedge i_clk) begin : monitor
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < PORTS; i++) begin
                req_head[i] = 0;
                req_fill[i] = 0;
            end
            routed_q.delete();
            err_cnt  = 0;
            word_cnt = 0;
            drop_cnt = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                route_word(i_s_tdata, want);
                if (want[OVF_BIT])
                    drop_cnt++;
                routed_q.insert(routed_q.size(), want);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (routed_q.size() == 0) begin
                    note_error($sformatf("unexpected word %0h", i_m_tdata));
                end else begin
                    want = routed_q.pop_front();
                    for (int o = 0; o < PORTS; o++) begin
                        check_field($sformatf("out%0d_valid", o),
                                    32'(want[o * OUT_SLOT_W]),
                                    32'(i_m_tdata[o * OUT_SLOT_W]));
                        check_field($sformatf("out%0d_tag", o),
                                    32'(want[o * OUT_SLOT_W + 1 +: TAG_W]),
                                    32'(i_m_tdata[o * OUT_SLOT_W + 1 +: TAG_W]));
                    end
                    check_field("overflow", 32'(want[OVF_BIT]), 32'(i_m_tdata[OVF_BIT]));
                end
                word_cnt++;
            end
        end
        o_errors     <= err_cnt;
        o_pending    <= routed_q.size();
        o_checked    <= word_cnt;
        o_drop_words <= drop_cnt;
    end

endmodule

@@ tb/sv/multicast_stub_router_tb.sv @@
// Stimulus, handshake pacing and verdict for the multicast stub router.
`timescale 1ns / 100ps
module multicast_stub_router_tb;
    import msr_pkg::*;

    localparam int NUM_INPUTS  = 4;
    localparam int NUM_OUTPUTS = 4;
    localparam int FIFO_DEPTH  = 128;
    localparam int TAG_BITS    = 16;
    localparam int RANDOM_WORDS = 800;
    localparam int STALL_LIMIT  = 2000;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata  = '0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;

    int errors;
    int pending;
    int checked;
    int drop_words;

    int src_idle = 15;
    int snk_idle = 54;
    int sent     = 0;
    int directed = 0;
    int quiet    = 0;

    multicast_stub_router #(
        .NUM_INPUTS (NUM_INPUTS),
        .NUM_OUTPUTS(NUM_OUTPUTS),
        .FIFO_DEPTH (FIFO_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    msr_route_checker #(
        .NUM_INPUTS (NUM_INPUTS),
        .NUM_OUTPUTS(NUM_OUTPUTS),
        .FIFO_DEPTH (FIFO_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_drop_words(drop_words)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= snk_idle);
    end

    // End the run when neither side moves a word for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("multicast_stub_router_tb: errors");
                $finish;
            end
        end
    end

    function automatic logic [IN_SLOT_W-1:0] frame(input logic v, input logic [TAG_W-1:0] tg,
                                                   input logic [MASK_W-1:0] mk);
        return {mk, tg, v};
    endfunction

    function automatic logic [IN_W-1:0] pack(input logic [IN_SLOT_W-1:0] s0,
                                             input logic [IN_SLOT_W-1:0] s1,
                                             input logic [IN_SLOT_W-1:0] s2,
                                             input logic [IN_SLOT_W-1:0] s3);
        return {{(IN_W - PORTS * IN_SLOT_W){1'b0}}, s3, s2, s1, s0};
    endfunction

    // Random frame; hot_pct biases the mask toward output 0 to build contention.
    function automatic logic [IN_SLOT_W-1:0] rand_frame(input int valid_pct, input int hot_pct);
        logic [MASK_W-1:0] mk;
        mk = MASK_W'($urandom);
        if ($urandom_range(99) < hot_pct)
            mk[0] = 1'b1;
        return frame($urandom_range(99) < valid_pct, TAG_W'($urandom), mk);
    endfunction

    // Hold the word until accepted; pacing phase follows the word count.
    task automatic send_word(input logic [IN_W-1:0] w);
        if (sent < 280) begin
            src_idle = 15;
            snk_idle = 54;
        end else if (sent < 560) begin
            src_idle = 54;
            snk_idle = 15;
        end else begin
            src_idle = 0;
            snk_idle = 0;
        end
        while ($urandom_range(99) < src_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w;
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
    endtask

    initial begin : stimulus
        logic [IN_W-1:0] plan [$];
        int              burst;
        int              len;
        int              vpct;
        int              hpct;
        int              random_sent;

        // all gaps, then single and multicast frames at the tag extremes
        plan = {plan, pack('0, '0, '0, '0)};
        plan = {plan, pack(frame(1, 16'h0000, 4'b0001), '0, '0, '0)};
        plan = {plan, pack('0, '0, '0, frame(1, 16'hFFFF, 4'b1111))};
        // every input asks for every output: highest input wins, rest wait
        plan = {plan, pack(frame(1, 16'h0A0A, 4'b1111), frame(1, 16'h1B1B, 4'b1111),
                           frame(1, 16'h2C2C, 4'b1111), frame(1, 16'h3D3D, 4'b1111))};
        plan = {plan, pack('0, '0, '0, '0)};
        plan = {plan, pack('0, '0, '0, '0)};
        plan = {plan, pack('0, '0, '0, '0)};
        // empty masks are queued and popped without serving
        plan = {plan, pack(frame(1, 16'hFFFF, 4'b0000), frame(1, 16'hFFFF, 4'b0000),
                           frame(1, 16'hFFFF, 4'b0000), frame(1, 16'hFFFF, 4'b0000))};
        plan = {plan, pack(frame(1, 16'h1234, 4'b1000), frame(1, 16'h5555, 4'b0100),
                           frame(1, 16'hAAAA, 4'b0100), '0)};
        // empty mask stuck behind a blocked front
        plan = {plan, pack(frame(1, 16'h0F0F, 4'b0001), '0, '0,
                           frame(1, 16'hF0F0, 4'b0001))};
        plan = {plan, pack(frame(1, 16'h00FF, 4'b0000), '0, '0, '0)};
        plan = {plan, pack(frame(1, 16'h8001, 4'b0010), frame(1, 16'h8002, 4'b0100),
                           frame(1, 16'h8003, 4'b1000), frame(1, 16'h8004, 4'b0001))};
        plan = {plan, pack(frame(1, 16'hFFFF, 4'b1111), frame(1, 16'hFFFF, 4'b1111),
                           frame(1, 16'hFFFF, 4'b1111), frame(1, 16'hFFFF, 4'b1111))};
        // gaps carrying junk tag and mask must be ignored
        plan = {plan, pack(frame(0, 16'hFFFF, 4'b1111), frame(0, 16'hFFFF, 4'b1111),
                           frame(0, 16'hFFFF, 4'b1111), frame(0, 16'hFFFF, 4'b1111))};
        plan = {plan, pack(frame(1, 16'h0000, 4'b0000), frame(1, 16'h0000, 4'b0000),
                           frame(1, 16'h0000, 4'b0000), frame(1, 16'h0000, 4'b0000))};
        plan = {plan, pack('0, '0, '0, '0)};
        plan = {plan, pack('0, '0, '0, '0)};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k])
            send_word(plan[k]);
        directed = sent;

        // Bursts: floods fill the low-priority queues until they overflow,
        // drains empty them, mixed traffic sits in between.
        random_sent = 0;
        while (random_sent < RANDOM_WORDS) begin
            burst = $urandom_range(2);
            case (burst)
                0: begin
                    len  = $urandom_range(160, 220);
                    vpct = 92;
                    hpct = 85;
                end
                1: begin
                    len  = $urandom_range(40, 150);
                    vpct = 10;
                    hpct = 30;
                end
                default: begin
                    len  = $urandom_range(30, 80);
                    vpct = 50;
                    hpct = 40;
                end
            endcase
            for (int n = 0; n < len && random_sent < RANDOM_WORDS; n++) begin
                send_word(pack(rand_frame(vpct, hpct), rand_frame(vpct, hpct),
                               rand_frame(vpct, hpct), rand_frame(vpct, hpct)));
                random_sent++;
            end
        end
        i_s_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);

        $display("sent %0d input words (%0d directed), checked %0d output words",
                 sent, directed, checked);
        $display("%0d output words carried a dropped-frame flag, %0d mismatches",
                 drop_words, errors);
        if (errors == 0 && pending == 0) begin
            $display("multicast_stub_router_tb: clean");
        end else begin
            $display("multicast_stub_router_tb: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/msr_pkg.sv
hw/rtl/msr_lane.sv
hw/rtl/multicast_stub_router.sv
tb/sv/msr_route_checker.sv
tb/sv/multicast_stub_router_tb.sv
